FILE: hw/rtl/mcfe_pkg.sv
package mcfe_pkg;

  localparam int FRAME_LEN   = 10;
  localparam int IDX_W       = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
  localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

  localparam logic [7:0] OP_DRIVE    = 8'h64;
  localparam logic [7:0] OP_QUERY    = 8'h74;
  localparam logic [7:0] OP_SET_MODE = 8'hA0;
  localparam logic [7:0] SYNC_0      = 8'hAA;
  localparam logic [7:0] SYNC_1      = 8'h55;
  localparam logic [7:0] SYNC_2      = 8'h53;
  localparam logic [7:0] CHECK_ADDR  = 8'hC8;
  localparam logic [7:0] CRC_POLY    = 8'h8C;

  typedef enum logic [2:0] {
    KIND_DRIVE    = 3'd0,
    KIND_QUERY    = 3'd1,
    KIND_SET_MODE = 3'd2,
    KIND_SET_ID   = 3'd3,
    KIND_CHECK    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  motor_id;
    logic [15:0] speed;
    logic [7:0]  accel;
    logic [7:0]  brake;
    logic [7:0]  mode;
  } cmd_t;

  // reflected CRC-8, one byte folded in
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // byte idx of the frame; crc is the running CRC over bytes 0 .. idx-1
  function automatic logic [7:0] frame_byte(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                                            input logic [7:0] crc);
    logic [7:0] v;
    v = 8'h00;
    case (cmd.kind)
      KIND_DRIVE: begin
        case (idx)
          4'd0: v = cmd.motor_id;
          4'd1: v = OP_DRIVE;
          4'd2: v = cmd.speed[15:8];
          4'd3: v = cmd.speed[7:0];
          4'd6: v = cmd.accel;
          4'd7: v = cmd.brake;
          4'd9: v = crc;
          default: v = 8'h00;
        endcase
      end
      KIND_QUERY: begin
        case (idx)
          4'd0: v = cmd.motor_id;
          4'd1: v = OP_QUERY;
          4'd9: v = crc;
          default: v = 8'h00;
        endcase
      end
      KIND_SET_MODE: begin
        case (idx)
          4'd0: v = cmd.motor_id;
          4'd1: v = OP_SET_MODE;
          4'd9: v = cmd.mode;
          default: v = 8'h00;
        endcase
      end
      KIND_SET_ID: begin
        case (idx)
          4'd0: v = SYNC_0;
          4'd1: v = SYNC_1;
          4'd2: v = SYNC_2;
          4'd3: v = cmd.motor_id;
          default: v = 8'h00;
        endcase
      end
      KIND_CHECK: begin
        case (idx)
          4'd0: v = CHECK_ADDR;
          4'd1: v = OP_DRIVE;
          4'd9: v = crc;
          default: v = 8'h00;
        endcase
      end
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/mcfe_cmd_if.sv
interface mcfe_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  motor_id;
  logic [15:0] speed;
  logic [7:0]  accel;
  logic [7:0]  brake;
  logic [7:0]  mode;

  modport source (output valid, req_type, motor_id, speed, accel, brake, mode, input ready);
  modport sink   (input valid, req_type, motor_id, speed, accel, brake, mode, output ready);
endinterface

FILE: hw/rtl/mcfe_byte_if.sv
interface mcfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_end;

  modport source (output valid, tx_byte, frame_end, input ready);
  modport sink   (input valid, tx_byte, frame_end, output ready);
endinterface

FILE: hw/rtl/mcfe_front.sv
module mcfe_front (
  mcfe_cmd_if.sink    cmd,
  input  logic        q_full,
  output logic        q_push,
  output mcfe_pkg::cmd_t q_data
);

  logic kind_ok;

  always_comb begin
    case (cmd.req_type) inside
      [3'd0:3'd4]: kind_ok = 1'b1;
      default:     kind_ok = 1'b0;
    endcase
  end

  // undefined kinds are taken and dropped
  assign cmd.ready = !q_full;
  assign q_push    = cmd.valid && !q_full && kind_ok;

  always_comb begin
    q_data.kind     = mcfe_pkg::kind_t'(cmd.req_type);
    q_data.motor_id = cmd.motor_id;
    q_data.speed    = cmd.speed;
    q_data.accel    = cmd.accel;
    q_data.brake    = cmd.brake;
    q_data.mode     = cmd.mode;
  end

endmodule

FILE: hw/rtl/mcfe_queue.sv
module mcfe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mcfe_pkg::cmd_t wr_data,
  input  logic           pop,
  output mcfe_pkg::cmd_t rd_data,
  output logic           full,
  output logic           empty
);

  mcfe_pkg::cmd_t mem [mcfe_pkg::QUEUE_DEPTH];
  logic [mcfe_pkg::QPTR_W-1:0] wr_ptr;
  logic [mcfe_pkg::QPTR_W-1:0] rd_ptr;
  logic [mcfe_pkg::QCNT_W-1:0] count;

  assign full    = (count == mcfe_pkg::QCNT_FULL);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mcfe_pkg::QPTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mcfe_pkg::QPTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/mcfe_back.sv
module mcfe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mcfe_pkg::cmd_t q_data,
  output logic           q_pop,
  mcfe_byte_if.source    tx
);

  mcfe_pkg::cmd_t              cur;
  logic                        active;
  logic [mcfe_pkg::IDX_W-1:0]  idx;
  logic [7:0]                  crc;
  logic                        out_valid;
  logic [7:0]                  out_byte;
  logic                        out_end;

  logic       load;
  logic       emit;
  logic       last;
  logic [7:0] byte_next;

  assign load      = !out_valid || tx.ready;
  assign emit      = active && load;
  assign last      = (idx == mcfe_pkg::LAST_IDX);
  assign byte_next = mcfe_pkg::frame_byte(cur, idx, crc);
  // fetch the next command as the last byte goes out, so frames run back to back
  assign q_pop     = !q_empty && (!active || (emit && last));

  assign tx.valid     = out_valid;
  assign tx.tx_byte   = out_byte;
  assign tx.frame_end = out_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (emit) begin
        if (last) begin
          active <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
      crc <= 8'h00;
    end else if (emit) begin
      crc <= mcfe_pkg::crc8_update(crc, byte_next);
    end
    if (emit) begin
      out_byte <= byte_next;
      out_end  <= last;
    end
  end

endmodule

FILE: hw/rtl/motor_command_frame_encoder.sv
// channel | dir | fields                                       | item
// --------+-----+----------------------------------------------+---------------------
// cmd     | in  | req_type motor_id speed accel brake mode      | one motor command
// tx      | out | tx_byte frame_end                             | one frame byte
//
// Each valid command yields ten tx items, one per cycle while tx is ready, all sent by
// the single byte serialiser in the back end, with frames running back to back.
// A two-entry command queue lets cmd be taken while a frame is still going out.
// Commands with an undefined kind are taken and produce no bytes.
// Synchronous reset empties the queue and the output register; no clearing pass.
module motor_command_frame_encoder (
  input logic         clk,
  input logic         rst,
  mcfe_cmd_if.sink    cmd,
  mcfe_byte_if.source tx
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  mcfe_pkg::cmd_t q_wr;
  mcfe_pkg::cmd_t q_rd;

  mcfe_front u_front (
    .cmd    (cmd),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr)
  );

  mcfe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  mcfe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd),
    .q_pop   (q_pop),
    .tx      (tx)
  );

endmodule

FILE: dv/motor_command_frame_encoder_tb.sv
`timescale 1ns / 1ps

module motor_command_frame_encoder_tb;

  localparam logic [2:0] KIND_RSVD_LO = 3'd5;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 60;
  localparam time RUN_LIMIT = 8_000_000;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  motor_id;
    logic [15:0] speed;
    logic [7:0]  accel;
    logic [7:0]  brake;
    logic [7:0]  mode;
    bit          typed;
    int          n_out;
    logic [79:0] frame;
  } cmd_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_beat_t;

  logic clk;
  logic rst;

  mcfe_cmd_if  cmd_if ();
  mcfe_byte_if tx_if ();

  motor_command_frame_encoder u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .tx  (tx_if)
  );

  cmd_row_t dir_rows[$];
  tx_beat_t frame_byte_q[$];
  int       err_cnt;
  bit       send_no_idle;
  bit       recv_no_idle;
  int       choke_req;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [7:0] crc8_maxim_calc(input logic [7:0] fb [mcfe_pkg::FRAME_LEN],
                                                 input int len);
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < len; i++) begin
      for (int b = 0; b < 8; b++) begin
        // reflected form: shift out lsb, feed data lsb first
        if (crc[0] ^ fb[i][b]) crc = (crc >> 1) ^ 8'h8C;
        else crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  function automatic int encode_frame(input cmd_row_t c,
                                      output logic [7:0] fb [mcfe_pkg::FRAME_LEN]);
    for (int k = 0; k < mcfe_pkg::FRAME_LEN; k++) fb[k] = 8'h00;
    case (c.kind)
      mcfe_pkg::KIND_DRIVE: begin
        fb[0] = c.motor_id;
        fb[1] = 8'h64;
        fb[2] = c.speed[15:8];
        fb[3] = c.speed[7:0];
        fb[6] = c.accel;
        fb[7] = c.brake;
        fb[9] = crc8_maxim_calc(fb, 9);
      end
      mcfe_pkg::KIND_QUERY: begin
        fb[0] = c.motor_id;
        fb[1] = 8'h74;
        fb[9] = crc8_maxim_calc(fb, 9);
      end
      mcfe_pkg::KIND_SET_MODE: begin
        fb[0] = c.motor_id;
        fb[1] = 8'hA0;
        fb[9] = c.mode;
      end
      mcfe_pkg::KIND_SET_ID: begin
        fb[0] = 8'hAA;
        fb[1] = 8'h55;
        fb[2] = 8'h53;
        fb[3] = c.motor_id;
      end
      mcfe_pkg::KIND_CHECK: begin
        fb[0] = 8'hC8;
        fb[1] = 8'h64;
        fb[9] = crc8_maxim_calc(fb, 9);
      end
      default: return 0;
    endcase
    return mcfe_pkg::FRAME_LEN;
  endfunction

  task automatic add_row(input logic [2:0] kind, input logic [7:0] motor_id,
                         input logic [15:0] speed, input logic [7:0] accel,
                         input logic [7:0] brake, input logic [7:0] mode,
                         input bit typed, input int n_out, input logic [79:0] frame);
    cmd_row_t r;
    r.kind = kind;
    r.motor_id = motor_id;
    r.speed = speed;
    r.accel = accel;
    r.brake = brake;
    r.mode = mode;
    r.typed = typed;
    r.n_out = n_out;
    r.frame = frame;
    dir_rows.push_back(r);
  endtask

  // edge values turn up often so that all-zero and all-one fields are common
  function automatic logic [15:0] pick_field();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic cmd_row_t random_cmd();
    cmd_row_t c;
    if ($urandom_range(99) < 5) c.kind = 3'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
    else c.kind = 3'($urandom_range(mcfe_pkg::KIND_CHECK, mcfe_pkg::KIND_DRIVE));
    c.motor_id = 8'(pick_field());
    c.speed = pick_field();
    c.accel = 8'(pick_field());
    c.brake = 8'(pick_field());
    c.mode = 8'(pick_field());
    c.typed = 1'b0;
    c.n_out = 0;
    c.frame = '0;
    return c;
  endfunction

  function automatic int pick_gap(input bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // called at a rising edge; returns at the edge the item is taken or after its gap
  task automatic send_cmd(input cmd_row_t c);
    logic [7:0] fb [mcfe_pkg::FRAME_LEN];
    int n;
    int gap;
    cmd_if.valid    <= 1'b1;
    cmd_if.req_type <= c.kind;
    cmd_if.motor_id <= c.motor_id;
    cmd_if.speed    <= c.speed;
    cmd_if.accel    <= c.accel;
    cmd_if.brake    <= c.brake;
    cmd_if.mode     <= c.mode;
    do @(posedge clk); while (!cmd_if.ready);
    if (c.typed) begin
      n = c.n_out;
      for (int k = 0; k < mcfe_pkg::FRAME_LEN; k++) fb[k] = c.frame[79 - 8 * k -: 8];
    end else begin
      n = encode_frame(c, fb);
    end
    for (int k = 0; k < n; k++) frame_byte_q.push_back('{data: fb[k], last: (k == n - 1)});
    gap = pick_gap(send_no_idle);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver back-pressure, with an occasional long hold-off on request
  initial begin
    int hold_left;
    int choke_seen;
    int r;
    hold_left = 0;
    choke_seen = 0;
    tx_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (choke_req != choke_seen) begin
        choke_seen = choke_req;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (rst) begin
        tx_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        tx_if.ready <= 1'b0;
        hold_left--;
      end else if (recv_no_idle) begin
        tx_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 70) begin
          tx_if.ready <= 1'b1;
        end else if (r < 97) begin
          tx_if.ready <= 1'b0;
          hold_left = $urandom_range(2, 0);
        end else begin
          tx_if.ready <= 1'b0;
          hold_left = $urandom_range(40, 10);
        end
      end
    end
  end

  always @(posedge clk) begin
    tx_beat_t exp_beat;
    if (!rst && tx_if.valid && tx_if.ready) begin
      if (frame_byte_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got tx_byte %02h frame_end %0b",
                 $time, tx_if.tx_byte, tx_if.frame_end);
        err_cnt++;
      end else begin
        exp_beat = frame_byte_q.pop_front();
        if (tx_if.tx_byte !== exp_beat.data) begin
          $display("%0t: tx_byte mismatch, expected %02h, got %02h",
                   $time, exp_beat.data, tx_if.tx_byte);
          err_cnt++;
        end
        if (tx_if.frame_end !== exp_beat.last) begin
          $display("%0t: frame_end mismatch, expected %0b, got %0b",
                   $time, exp_beat.last, tx_if.frame_end);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    err_cnt = 0;
    send_no_idle = 1'b0;
    recv_no_idle = 1'b0;
    choke_req = 0;
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.req_type = mcfe_pkg::KIND_DRIVE;
    cmd_if.motor_id = 8'h00;
    cmd_if.speed = 16'h0000;
    cmd_if.accel = 8'h00;
    cmd_if.brake = 8'h00;
    cmd_if.mode = 8'h00;

    // frames typed in where they can be read straight off the layout
    add_row(mcfe_pkg::KIND_SET_ID, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1,
            mcfe_pkg::FRAME_LEN, 80'hAA55_5300_0000_0000_0000);
    add_row(mcfe_pkg::KIND_SET_ID, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1,
            mcfe_pkg::FRAME_LEN, 80'hAA55_53FF_0000_0000_0000);
    add_row(mcfe_pkg::KIND_SET_ID, 8'h5A, 16'hA5A5, 8'h3C, 8'hC3, 8'h81, 1,
            mcfe_pkg::FRAME_LEN, 80'hAA55_535A_0000_0000_0000);
    add_row(mcfe_pkg::KIND_SET_MODE, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1,
            mcfe_pkg::FRAME_LEN, 80'h00A0_0000_0000_0000_0000);
    add_row(mcfe_pkg::KIND_SET_MODE, 8'hFF, 16'h0000, 8'h00, 8'h00, 8'hFF, 1,
            mcfe_pkg::FRAME_LEN, 80'hFFA0_0000_0000_0000_00FF);
    add_row(mcfe_pkg::KIND_SET_MODE, 8'h5A, 16'hFFFF, 8'hFF, 8'hFF, 8'hA5, 1,
            mcfe_pkg::FRAME_LEN, 80'h5AA0_0000_0000_0000_00A5);
    // undefined kinds are taken and send nothing
    add_row(KIND_RSVD_LO, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1, 0, '0);
    add_row(3'd6, 8'h12, 16'h3456, 8'h78, 8'h9A, 8'hBC, 1, 0, '0);
    add_row(KIND_RSVD_HI, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1, 0, '0);
    // CRC-bearing frames, and one mode frame, go through the predictor
    add_row(mcfe_pkg::KIND_DRIVE, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 0, '0);
    add_row(mcfe_pkg::KIND_DRIVE, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, '0);
    add_row(mcfe_pkg::KIND_DRIVE, 8'h01, 16'h8001, 8'h01, 8'h80, 8'h00, 0, 0, '0);
    add_row(mcfe_pkg::KIND_DRIVE, 8'h80, 16'h00FF, 8'h00, 8'hFF, 8'hFF, 0, 0, '0);
    add_row(mcfe_pkg::KIND_DRIVE, 8'h7F, 16'hFF00, 8'hFF, 8'h00, 8'h00, 0, 0, '0);
    add_row(mcfe_pkg::KIND_QUERY, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 0, '0);
    add_row(mcfe_pkg::KIND_QUERY, 8'hFF, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 0, '0);
    add_row(mcfe_pkg::KIND_QUERY, 8'h3C, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, '0);
    add_row(mcfe_pkg::KIND_CHECK, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 0, '0);
    add_row(mcfe_pkg::KIND_CHECK, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, '0);
    add_row(mcfe_pkg::KIND_SET_MODE, 8'h81, 16'h1234, 8'h56, 8'h78, 8'h7E, 0, 0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_cmd(dir_rows[i]);

    for (int i = 0; i < 110; i++) send_cmd(random_cmd());

    // hold the receiver off and keep offering back to back until the input stalls
    choke_req++;
    send_no_idle = 1'b1;
    for (int i = 0; i < 40; i++) send_cmd(random_cmd());

    recv_no_idle = 1'b1;
    for (int i = 0; i < 60; i++) send_cmd(random_cmd());
    send_no_idle = 1'b0;
    recv_no_idle = 1'b0;

    for (int i = 0; i < 70; i++) send_cmd(random_cmd());
    cmd_if.valid <= 1'b0;

    while (frame_byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
